[sv/sprite_chain_tile_placement_macros.svh]
// assertion macros shared by the sprite chain tile placement modules
`ifndef SPRITE_CHAIN_TILE_PLACEMENT_MACROS_SVH
`define SPRITE_CHAIN_TILE_PLACEMENT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SCTP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sctp check failed");

// next-cycle implication, checked out of reset
`define SCTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sctp check failed");

`endif

[sv/sctp_pkg.sv]
// types, constants and the divider step function for sprite chain tile placement
`timescale 1ns / 1ps

package sctp_pkg;

  // divider geometry: numerator/quotient shift word, steps per stage
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_STEPS;

  localparam int unsigned STEP_W = 29;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned TILE_W = 20;
  localparam int unsigned ATTR_TILE_W = 19;

  // zoom factors and factor * 65536 numerators
  localparam logic [15:0]      ZOOM_LARGE = 16'h1000;
  localparam logic [15:0]      ZOOM_SMALL = 16'h0100;
  localparam logic [DIV_W-1:0] NUM_LARGE  = 32'h1000_0000;
  localparam logic [DIV_W-1:0] NUM_SMALL  = 32'h0100_0000;

  localparam logic [10:0] Z_HIDDEN = 11'h7ff;

  // bit positions in the head entry words
  localparam int unsigned DISABLE_BIT = 26;
  localparam int unsigned FLIP_X_BIT  = 25;
  localparam int unsigned FLIP_Y_BIT  = 24;
  localparam int unsigned BLEND_BIT   = 23;
  localparam int unsigned INLINE_BIT  = 8;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_OFFSET_X   = 2'd0,
    REG_OFFSET_Y   = 2'd1,
    REG_LARGE_ZOOM = 2'd2,
    REG_EIGHT_BIT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    logic        large_zoom;
    logic        eight_bit;
  } cfg_t;

  // one lane of the restoring divider: partial remainder, numerator/quotient word, divisor
  typedef struct packed {
    logic [15:0]      rem;
    logic [DIV_W-1:0] nq;
    logic [15:0]      dv;
  } div_lane_t;

  typedef struct packed {
    div_lane_t x;
    div_lane_t y;
  } div_pair_t;

  // per-tile data that rides alongside the divider
  typedef struct packed {
    logic              skip;
    logic [TILE_W-1:0] tile;
    logic [7:0]        palette;
    logic              flip_x;
    logic              flip_y;
    logic              blend;
    logic [POS_W-1:0]  base_x;
    logic [POS_W-1:0]  base_y;
    logic [POS_W-1:0]  mult_x;
    logic [POS_W-1:0]  mult_y;
  } tile_info_t;

  // DIV_STEPS restoring steps: numerator bits leave the top of nq, quotient bits enter the bottom
  function automatic div_lane_t div_steps(div_lane_t a);
    div_lane_t   r;
    logic [16:0] trial;
    r = a;
    for (int i = 0; i < int'(DIV_STEPS); i++) begin
      trial = {r.rem, r.nq[DIV_W-1]};
      if (trial >= {1'b0, r.dv}) begin
        r.rem = 16'(trial - {1'b0, r.dv});
        r.nq  = {r.nq[DIV_W-2:0], 1'b1};
      end else begin
        r.rem = trial[15:0];
        r.nq  = {r.nq[DIV_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[sv/sctp_decode.sv]
// front stage: field extraction, skip, tile and palette, base positions, divider setup
`timescale 1ns / 1ps

module sctp_decode (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sctp_pkg::cfg_t           cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [31:0]              position_word_i,
  input  logic [31:0]              zoom_word_i,
  input  logic [31:0]              chain_word_i,
  input  logic [31:0]              head_palette_word_i,
  input  logic [31:0]              head_attr_word_i,
  input  logic [31:0]              inline_palette_word_i,
  input  logic [31:0]              inline_attr_word_i,
  input  logic [3:0]               tile_col_i,
  input  logic [3:0]               tile_row_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output sctp_pkg::div_pair_t      out_div_o,
  output sctp_pkg::tile_info_t     out_info_o
);

  logic                                 valid_q;
  logic                                 adv;
  sctp_pkg::div_pair_t                  div_d, div_q;
  sctp_pkg::tile_info_t                 info_d, info_q;
  logic [15:0]                          factor;
  logic [15:0]                          zoom_x, zoom_y;
  logic [sctp_pkg::DIV_W-1:0]           numer;
  logic [3:0]                           size_x, size_y;
  logic                                 is_inline;
  logic [10:0]                          zval;
  logic [sctp_pkg::ATTR_TILE_W-1:0]     tile_sel, tile_sh;
  logic [7:0]                           pal_sel;
  logic [8:0]                           lin_idx;

  // field split and divider operands
  always_comb begin
    factor    = cfg_i.large_zoom ? sctp_pkg::ZOOM_LARGE : sctp_pkg::ZOOM_SMALL;
    numer     = cfg_i.large_zoom ? sctp_pkg::NUM_LARGE : sctp_pkg::NUM_SMALL;
    zoom_x    = zoom_word_i[15:0];
    zoom_y    = zoom_word_i[31:16];
    size_x    = chain_word_i[7:4];
    size_y    = chain_word_i[3:0];
    is_inline = chain_word_i[sctp_pkg::INLINE_BIT];
    zval      = chain_word_i[26:16];

    div_d.x.rem = '0;
    div_d.x.nq  = numer;
    div_d.x.dv  = (zoom_x == 16'd0) ? factor : zoom_x;
    div_d.y.rem = '0;
    div_d.y.nq  = numer;
    div_d.y.dv  = (zoom_y == 16'd0) ? factor : zoom_y;
  end

  // tile number, palette, flips and position terms
  always_comb begin
    tile_sel = is_inline ? inline_attr_word_i[sctp_pkg::ATTR_TILE_W-1:0]
                         : head_attr_word_i[sctp_pkg::ATTR_TILE_W-1:0];
    pal_sel  = is_inline ? inline_palette_word_i[23:16] : head_palette_word_i[23:16];
    tile_sh  = cfg_i.eight_bit ? tile_sel : (tile_sel >> 1);
    lin_idx  = 9'(tile_row_i) * (9'(size_x) + 9'd1) + 9'(tile_col_i);

    info_d.skip    = head_attr_word_i[sctp_pkg::DISABLE_BIT] | (zval == sctp_pkg::Z_HIDDEN);
    info_d.tile    = sctp_pkg::TILE_W'(tile_sh)
                   + (is_inline ? '0 : sctp_pkg::TILE_W'(lin_idx));
    info_d.palette = cfg_i.eight_bit ? pal_sel : {4'h0, pal_sel[3:0]};
    info_d.flip_x  = head_attr_word_i[sctp_pkg::FLIP_X_BIT];
    info_d.flip_y  = head_attr_word_i[sctp_pkg::FLIP_Y_BIT];
    info_d.blend   = head_attr_word_i[sctp_pkg::BLEND_BIT];
    info_d.base_x  = position_word_i[9:0] + cfg_i.offset_x[9:0];
    info_d.base_y  = position_word_i[25:16] + cfg_i.offset_y[9:0];
    // flipped tiles step back from the far end of the chain
    info_d.mult_x  = info_d.flip_x ? (10'(size_x) - 10'(tile_col_i)) : 10'(tile_col_i);
    info_d.mult_y  = info_d.flip_y ? (10'(size_y) - 10'(tile_row_i)) : 10'(tile_row_i);
  end

  // stage advances when empty or when the next stage takes the beat
  assign adv        = ~valid_q | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      div_q  <= div_d;
      info_q <= info_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_div_o   = div_q;
  assign out_info_o  = info_q;

endmodule

[sv/sctp_div_stage.sv]
// one registered stage of the pipelined zoom divider, both axes side by side
`timescale 1ns / 1ps
`include "sprite_chain_tile_placement_macros.svh"

module sctp_div_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sctp_pkg::div_pair_t  in_div_i,
  input  sctp_pkg::tile_info_t in_info_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sctp_pkg::div_pair_t  out_div_o,
  output sctp_pkg::tile_info_t out_info_o
);

  logic                 valid_q;
  logic                 adv;
  sctp_pkg::div_pair_t  div_d, div_q;
  sctp_pkg::tile_info_t info_q;

  // a group of quotient bits per axis
  always_comb begin
    div_d.x = sctp_pkg::div_steps(in_div_i.x);
    div_d.y = sctp_pkg::div_steps(in_div_i.y);
  end

  assign adv        = ~valid_q | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      div_q  <= div_d;
      info_q <= in_info_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_div_o   = div_q;
  assign out_info_o  = info_q;

  // partial remainders stay below their divisors
  `SCTP_ASSERT_IMPLY(a_rem_below_div, clk_i, rst_ni, valid_q, (div_q.x.rem < div_q.x.dv) && (div_q.y.rem < div_q.y.dv))
  // a stalled beat is kept
  `SCTP_ASSERT_NEXT(a_stall_keeps, clk_i, rst_ni, valid_q && !out_ready_i, valid_q)

endmodule

[sv/sctp_place.sv]
// output stage: chain step from the quotient, wrapped position, skip masking
`timescale 1ns / 1ps

module sctp_place (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sctp_pkg::div_pair_t                 in_div_i,
  input  sctp_pkg::tile_info_t                in_info_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                skip_o,
  output logic [sctp_pkg::TILE_W-1:0]         tile_number_o,
  output logic [7:0]                          palette_o,
  output logic signed [sctp_pkg::POS_W-1:0]   draw_x_o,
  output logic signed [sctp_pkg::POS_W-1:0]   draw_y_o,
  output logic                                flip_x_o,
  output logic                                flip_y_o,
  output logic [sctp_pkg::STEP_W-1:0]         zoom_x_step_o,
  output logic [sctp_pkg::STEP_W-1:0]         zoom_y_step_o,
  output logic                                additive_blend_o
);

  logic                              valid_q;
  logic                              adv;
  logic [sctp_pkg::STEP_W-1:0]       step_x, step_y;
  logic [sctp_pkg::POS_W-1:0]        inc_x, inc_y;
  logic [2*sctp_pkg::POS_W-1:0]      prod_x, prod_y;
  logic [sctp_pkg::POS_W-1:0]        pos_x, pos_y;
  logic                              skip_q;
  logic [sctp_pkg::TILE_W-1:0]       tile_q;
  logic [7:0]                        pal_q;
  logic [sctp_pkg::POS_W-1:0]        pos_x_q, pos_y_q;
  logic                              flip_x_q, flip_y_q, blend_q;
  logic [sctp_pkg::STEP_W-1:0]       step_x_q, step_y_q;

  // chain step is the zoom step over 4096; only its low ten bits reach the position
  always_comb begin
    step_x = in_div_i.x.nq[sctp_pkg::STEP_W-1:0];
    step_y = in_div_i.y.nq[sctp_pkg::STEP_W-1:0];
    inc_x  = step_x[12 +: sctp_pkg::POS_W];
    inc_y  = step_y[12 +: sctp_pkg::POS_W];
    prod_x = inc_x * in_info_i.mult_x;
    prod_y = inc_y * in_info_i.mult_y;
    pos_x  = in_info_i.base_x + prod_x[sctp_pkg::POS_W-1:0];
    pos_y  = in_info_i.base_y + prod_y[sctp_pkg::POS_W-1:0];
  end

  assign adv        = ~valid_q | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  // result register, everything but skip forced to zero on a skipped tile
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      skip_q <= in_info_i.skip;
      if (in_info_i.skip) begin
        tile_q   <= '0;
        pal_q    <= '0;
        pos_x_q  <= '0;
        pos_y_q  <= '0;
        flip_x_q <= 1'b0;
        flip_y_q <= 1'b0;
        blend_q  <= 1'b0;
        step_x_q <= '0;
        step_y_q <= '0;
      end else begin
        tile_q   <= in_info_i.tile;
        pal_q    <= in_info_i.palette;
        pos_x_q  <= pos_x;
        pos_y_q  <= pos_y;
        flip_x_q <= in_info_i.flip_x;
        flip_y_q <= in_info_i.flip_y;
        blend_q  <= in_info_i.blend;
        step_x_q <= step_x;
        step_y_q <= step_y;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign skip_o           = skip_q;
  assign tile_number_o    = tile_q;
  assign palette_o        = pal_q;
  assign draw_x_o         = $signed(pos_x_q);
  assign draw_y_o         = $signed(pos_y_q);
  assign flip_x_o         = flip_x_q;
  assign flip_y_o         = flip_y_q;
  assign zoom_x_step_o    = step_x_q;
  assign zoom_y_step_o    = step_y_q;
  assign additive_blend_o = blend_q;

endmodule

[sv/sprite_chain_tile_placement.sv]
// top level of sprite chain tile placement: config registers and the stage chain
//
//  channel   signals                          beat
//  in        in_valid_i / in_ready_o          one tile: head words, inline words, col, row
//  out       out_valid_o / out_ready_i        one placement: skip, tile, palette, pos, zoom
//  cfg       cfg_we_i, cfg_idx_i, cfg_data_i  one register write, no wait
//
//  one tile per cycle sustained while out_ready_i is high; stages: decode, 8 divider stages, output
//  the divider retires 4 quotient bits per stage over a 32-bit word, which sets the depth
//  each stage moves on when empty or when its successor takes the beat, so bubbles close
//  a stall holds every stage in place; nothing is dropped or repeated
//  reset clears the valid bits and config registers; no clearing pass
`timescale 1ns / 1ps
`include "sprite_chain_tile_placement_macros.svh"

module sprite_chain_tile_placement (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        position_word_i,
  input  logic [31:0]        zoom_word_i,
  input  logic [31:0]        chain_word_i,
  input  logic [31:0]        head_palette_word_i,
  input  logic [31:0]        head_attr_word_i,
  input  logic [31:0]        inline_palette_word_i,
  input  logic [31:0]        inline_attr_word_i,
  input  logic [3:0]         tile_col_i,
  input  logic [3:0]         tile_row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               skip_o,
  output logic [19:0]        tile_number_o,
  output logic [7:0]         palette_o,
  output logic signed [9:0]  draw_x_o,
  output logic signed [9:0]  draw_y_o,
  output logic               flip_x_o,
  output logic               flip_y_o,
  output logic [28:0]        zoom_x_step_o,
  output logic [28:0]        zoom_y_step_o,
  output logic               additive_blend_o
);

  sctp_pkg::cfg_t       cfg_q, cfg_d;
  logic                 valid   [0:sctp_pkg::DIV_STAGES];
  logic                 ready   [0:sctp_pkg::DIV_STAGES];
  sctp_pkg::div_pair_t  div_pipe  [0:sctp_pkg::DIV_STAGES];
  sctp_pkg::tile_info_t info_pipe [0:sctp_pkg::DIV_STAGES];

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sctp_pkg::cfg_reg_e'(cfg_idx_i))
        sctp_pkg::REG_OFFSET_X:   cfg_d.offset_x   = cfg_data_i;
        sctp_pkg::REG_OFFSET_Y:   cfg_d.offset_y   = cfg_data_i;
        sctp_pkg::REG_LARGE_ZOOM: cfg_d.large_zoom = cfg_data_i[0];
        sctp_pkg::REG_EIGHT_BIT:  cfg_d.eight_bit  = cfg_data_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front stage
  sctp_decode u_decode (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .position_word_i       (position_word_i),
    .zoom_word_i           (zoom_word_i),
    .chain_word_i          (chain_word_i),
    .head_palette_word_i   (head_palette_word_i),
    .head_attr_word_i      (head_attr_word_i),
    .inline_palette_word_i (inline_palette_word_i),
    .inline_attr_word_i    (inline_attr_word_i),
    .tile_col_i            (tile_col_i),
    .tile_row_i            (tile_row_i),
    .out_valid_o           (valid[0]),
    .out_ready_i           (ready[0]),
    .out_div_o             (div_pipe[0]),
    .out_info_o            (info_pipe[0])
  );

  // divider stages
  for (genvar g = 0; g < int'(sctp_pkg::DIV_STAGES); g++) begin : g_div
    sctp_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[g]),
      .in_ready_o  (ready[g]),
      .in_div_i    (div_pipe[g]),
      .in_info_i   (info_pipe[g]),
      .out_valid_o (valid[g+1]),
      .out_ready_i (ready[g+1]),
      .out_div_o   (div_pipe[g+1]),
      .out_info_o  (info_pipe[g+1])
    );
  end

  // output register
  sctp_place u_place (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (valid[sctp_pkg::DIV_STAGES]),
    .in_ready_o       (ready[sctp_pkg::DIV_STAGES]),
    .in_div_i         (div_pipe[sctp_pkg::DIV_STAGES]),
    .in_info_i        (info_pipe[sctp_pkg::DIV_STAGES]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .skip_o           (skip_o),
    .tile_number_o    (tile_number_o),
    .palette_o        (palette_o),
    .draw_x_o         (draw_x_o),
    .draw_y_o         (draw_y_o),
    .flip_x_o         (flip_x_o),
    .flip_y_o         (flip_y_o),
    .zoom_x_step_o    (zoom_x_step_o),
    .zoom_y_step_o    (zoom_y_step_o),
    .additive_blend_o (additive_blend_o)
  );

  // skipped tiles carry nothing else
  `SCTP_ASSERT_IMPLY(a_skip_clears, clk_i, rst_ni, out_valid_o && skip_o, (tile_number_o == '0) && (zoom_x_step_o == '0) && (draw_x_o == '0) && (palette_o == '0))
  // a live tile always has a nonzero step no larger than 2^28
  `SCTP_ASSERT_IMPLY(a_step_range, clk_i, rst_ni, out_valid_o && !skip_o, (zoom_x_step_o != '0) && (zoom_y_step_o != '0) && (zoom_x_step_o <= 29'h1000_0000) && (zoom_y_step_o <= 29'h1000_0000))
  // four-bit mode keeps the palette in its low nibble
  `SCTP_ASSERT_IMPLY(a_pal_nibble, clk_i, rst_ni, out_valid_o && !cfg_q.eight_bit, palette_o[7:4] == 4'h0)

endmodule
